@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Concurrent assertion wrappers with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property, switched off while reset is high
`define LKV_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// assert a property at every clock edge, reset included
`define LKV_ASSERT_ANY(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

@@ hdl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// Types, sizes and codes of the LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

   // number of cells in the row
   localparam int ENTRIES = 8;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int AGE_W = IDX_W;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(ENTRIES - 1);

   // operation codes
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   // configuration register map
   localparam int          CSR_ADDR_W      = 3;
   localparam logic        CSR_IDX_ACTIVE  = 1'b0;
   localparam logic [3:0]  ACTIVE_RESET    = 4'd8;

   // read result on a get miss
   localparam logic signed [31:0] MISS_VALUE = -32'sd1;

   typedef struct packed {
      logic               kind;
      logic [31:0]        key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
   } rsp_type;

   // search token walking the cell row
   typedef struct packed {
      logic               valid;
      logic               found;
      logic [IDX_W-1:0]   slot;
      logic [AGE_W-1:0]   hit_age;
      logic signed [31:0] hit_value;
      logic               empty_found;
      logic [IDX_W-1:0]   empty_idx;
      logic [AGE_W-1:0]   max_age;
      logic [IDX_W-1:0]   max_idx;
   } tok_type;

   // update broadcast to every cell
   typedef struct packed {
      logic               en;
      logic               hit;
      logic               put;
      logic [IDX_W-1:0]   slot;
      logic [AGE_W-1:0]   bound;
      logic [31:0]        key;
      logic signed [31:0] value;
   } cmd_type;

endpackage

`default_nettype wire

@@ hdl/lru_key_value_cache_top.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Use:
//   req channel (valid/ready) carries one item: get (kind 0) or put (kind 1)
//   with key and value. rsp channel returns one item per request: hit flag
//   and read value (stored value on get hit, -1 on get miss, 0 on put).
//   csr port holds active_entries at address 0 (low 4 bits); 0 acts as 1,
//   values above ENTRIES act as ENTRIES.
// Timing:
//   A search token walks the row of ENTRIES cells, one cell per cycle; the
//   finished token is registered, then, unless a get misses, one update is
//   sent to all cells at once as the result goes to the output register.
//   One item is in flight at a time; the next is accepted while the previous
//   result still waits in the output register.
// Reset:
//   Synchronous. All entries become empty with age 0, active_entries
//   returns to 8, no result is pending.
// Stall:
//   While rsp_ready is low a finished result holds in the output register;
//   a following item completes its search and then waits before updating.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top
   import lkv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY
   } state_type;

   state_type        state_ff;
   logic [3:0]       active_ff;
   req_type          req_ff;
   logic             launch_ff;
   tok_type          final_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [CNT_W-1:0] used_n;
   logic             out_free;
   logic             accept;
   cmd_type          cmd;
   tok_type          tok_link [ENTRIES+1];
   rsp_type          rsp_in;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_ACTIVE) ? {28'd0, active_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == CSR_IDX_ACTIVE)) begin
         active_ff <= csr_pwdata[3:0];
      end
   end

   // clamp the entry count to 1..ENTRIES
   always_comb begin
      priority if (active_ff == 4'd0) begin
         used_n = CNT_W'(1);
      end else if ({28'd0, active_ff} > 32'(ENTRIES)) begin
         used_n = CNT_W'(ENTRIES);
      end else begin
         used_n = CNT_W'(active_ff);
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // seed the search token
   always_comb begin
      tok_link[0]             = '0;
      tok_link[0].valid       = launch_ff;
   end

   // row of cells
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_W'(g)),
         .used_n     (used_n),
         .search_key (req_ff.key),
         .tok_i      (tok_link[g]),
         .tok_o      (tok_link[g+1]),
         .cmd        (cmd)
      );
   end

   // update command from the finished search
   always_comb begin
      cmd.en    = (state_ff == ST_APPLY) && out_free
                  && (final_ff.found || (req_ff.kind == KIND_PUT));
      cmd.hit   = final_ff.found;
      cmd.put   = req_ff.kind == KIND_PUT;
      cmd.slot  = final_ff.found ? final_ff.slot :
                  (final_ff.empty_found ? final_ff.empty_idx : final_ff.max_idx);
      cmd.bound = final_ff.hit_age;
      cmd.key   = req_ff.key;
      cmd.value = req_ff.value;
   end

   // result of the item
   always_comb begin
      rsp_in.hit = final_ff.found;
      priority if (req_ff.kind == KIND_PUT) begin
         rsp_in.read_value = 32'sd0;
      end else if (final_ff.found) begin
         rsp_in.read_value = final_ff.hit_value;
      end else begin
         rsp_in.read_value = MISS_VALUE;
      end
   end

   // sequencer: accept, wait for the token, apply and post the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff <= accept;
         // drop a taken result unless a new one replaces it
         if (rsp_valid_ff && rsp_ready && !((state_ff == ST_APPLY) && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_ff    <= req_data;
                  state_ff  <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (tok_link[ENTRIES].valid) begin
                  final_ff <= tok_link[ENTRIES];
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= rsp_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/lkv_cell.sv @@
// ----------------------------------------------------------------------------
// lkv_cell
// One cache entry: key, value, valid and age, plus one stage of the search
// token that walks the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell
   import lkv_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] cell_idx,
   input  wire logic [CNT_W-1:0] used_n,
   input  wire logic [31:0]      search_key,
   input  wire tok_type          tok_i,
   output tok_type               tok_o,
   input  wire cmd_type          cmd
);

   logic               valid_ff;
   logic [AGE_W-1:0]   age_ff;
   logic [31:0]        key_ff;
   logic signed [31:0] value_ff;
   tok_type            tok_ff;
   tok_type            tok_in;

   logic in_use;
   logic match;
   logic empty;
   logic older;
   logic is_slot;

   assign in_use  = CNT_W'(cell_idx) < used_n;
   assign match   = in_use && valid_ff && (key_ff == search_key) && !tok_i.found;
   assign empty   = in_use && !valid_ff && !tok_i.empty_found;
   assign older   = in_use && (age_ff > tok_i.max_age);
   assign is_slot = cmd.slot == cell_idx;

   // fold this entry into the passing token
   always_comb begin
      tok_in = tok_i;
      if (match) begin
         tok_in.found     = 1'b1;
         tok_in.slot      = cell_idx;
         tok_in.hit_age   = age_ff;
         tok_in.hit_value = value_ff;
      end
      if (empty) begin
         tok_in.empty_found = 1'b1;
         tok_in.empty_idx   = cell_idx;
      end
      if (older) begin
         tok_in.max_age = age_ff;
         tok_in.max_idx = cell_idx;
      end
   end

   // hand the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_i.valid;
      end
      tok_ff.found       <= tok_in.found;
      tok_ff.slot        <= tok_in.slot;
      tok_ff.hit_age     <= tok_in.hit_age;
      tok_ff.hit_value   <= tok_in.hit_value;
      tok_ff.empty_found <= tok_in.empty_found;
      tok_ff.empty_idx   <= tok_in.empty_idx;
      tok_ff.max_age     <= tok_in.max_age;
      tok_ff.max_idx     <= tok_in.max_idx;
   end

   assign tok_o = tok_ff;

   // apply the broadcast update: refresh the chosen entry, age the other valid ones (on a hit only the younger ones)
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= '0;
      end else if (cmd.en && in_use) begin
         if (is_slot) begin
            age_ff <= '0;
            if (!cmd.hit) begin
               valid_ff <= 1'b1;
            end
         end else if (valid_ff && (!cmd.hit || (age_ff < cmd.bound))
                      && (age_ff < AGE_MAX)) begin
            age_ff <= age_ff + 1'b1;
         end
      end
   end

   // payload of the entry
   always_ff @(posedge clock) begin
      if (cmd.en && in_use && is_slot) begin
         if (!cmd.hit) begin
            key_ff   <= cmd.key;
            value_ff <= cmd.value;
         end else if (cmd.put) begin
            value_ff <= cmd.value;
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/lkv_checker.sv @@
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks of the LRU key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lkv_checker
   import lkv_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result stays posted
   `LKV_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // a miss reads either -1 or 0 (-1 on a get, 0 on a put; the kind is not checked)
   `LKV_ASSERT_RST(a_miss_value, clock, reset,
      rsp_valid && !rsp_data.hit |-> (rsp_data.read_value == MISS_VALUE) || (rsp_data.read_value == 32'sd0))

   // one item at a time: busy right after an accept
   `LKV_ASSERT_RST(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)

   // reset drops any pending result
   `LKV_ASSERT_ANY(a_reset_clears, clock, reset |=> !rsp_valid)

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (.*);

`default_nettype wire
